// File: rtl/m3inv_pkg.sv
// Shared widths, pipeline layout and register map of the 3x3 matrix inverse.
package m3inv_pkg;

   localparam int ELEM_W   = 32;   // Q16.16 element
   localparam int COF_W    = 64;   // Q32.32 cofactor
   localparam int PROD_W   = 96;   // cofactor times element
   localparam int DET_W    = 98;   // signed Q48.48 determinant with headroom
   localparam int DMAG_W   = 97;   // determinant magnitude
   localparam int REM_W    = 96;   // divider remainder (cofactor magnitude << 32)
   localparam int QUO_W    = 33;   // quotient bits kept, one above the saturation limit
   localparam int THR_W    = 63;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;

   // Register stage layout: five front stages, a magnitude stage, the divider steps, one output stage.
   localparam int STG_DIV0  = 5;
   localparam int DIV_STEPS = QUO_W;
   localparam int NSTG      = STG_DIV0 + DIV_STEPS + 2;

   // Register index, taken from address bit 3 (eight bytes per register).
   typedef enum logic {
      REG_DET_THRESHOLD = 1'b0
   } csr_reg_type;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;

endpackage

// File: rtl/matrix3x3_inverse.sv
// 3x3 matrix inverse by the adjugate, as a fully pipelined fixed-point datapath.
//
// Usage: one matrix of nine signed Q16.16 elements arrives as a beat on the
// req_ channel (valid/ready); one beat on the rsp_ channel returns the nine
// inverse elements (Q16.16, saturated), a singular flag and an overflow flag.
// The determinant is exact Q48.48; when its magnitude is at or below
// det_threshold (APB register at byte address 0) the beat carries zeros with
// singular set.
// From an accepted request beat to the response beat: 18 multipliers and
// a subtract build the cofactors, split 64x32 partial products and two
// adders build the determinant, a magnitude and threshold stage follows,
// then a restoring divider with one quotient bit per stage (33 stages, nine
// lanes) and a saturating output register. Throughput is one matrix per
// cycle while rsp_ready is high. Each stage holds its beat until the
// next stage is free, so when the receiver stalls the pipeline fills up
// bubble-free and req_ready drops only once every stage holds a beat.
// Synchronous reset empties the pipeline and clears det_threshold to zero.
module matrix3x3_inverse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  m3inv_pkg::elem_type            req_in_r0c0,
   input  m3inv_pkg::elem_type            req_in_r0c1,
   input  m3inv_pkg::elem_type            req_in_r0c2,
   input  m3inv_pkg::elem_type            req_in_r1c0,
   input  m3inv_pkg::elem_type            req_in_r1c1,
   input  m3inv_pkg::elem_type            req_in_r1c2,
   input  m3inv_pkg::elem_type            req_in_r2c0,
   input  m3inv_pkg::elem_type            req_in_r2c1,
   input  m3inv_pkg::elem_type            req_in_r2c2,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output m3inv_pkg::elem_type            rsp_inv_r0c0,
   output m3inv_pkg::elem_type            rsp_inv_r0c1,
   output m3inv_pkg::elem_type            rsp_inv_r0c2,
   output m3inv_pkg::elem_type            rsp_inv_r1c0,
   output m3inv_pkg::elem_type            rsp_inv_r1c1,
   output m3inv_pkg::elem_type            rsp_inv_r1c2,
   output m3inv_pkg::elem_type            rsp_inv_r2c0,
   output m3inv_pkg::elem_type            rsp_inv_r2c1,
   output m3inv_pkg::elem_type            rsp_inv_r2c2,
   output logic                           rsp_singular,
   output logic                           rsp_overflow,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [m3inv_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [m3inv_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [m3inv_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import m3inv_pkg::*;

   // Configuration register.
   logic [THR_W-1:0] thr_ff;

   // Stage valid bits and per-stage load enables.
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] ld;

   // Input matrix view.
   elem_type m_in [3][3];

   // Stage 0: cofactor products and the first column.
   cof_type  pa_ff [3][3];
   cof_type  pb_ff [3][3];
   elem_type col0_1_ff [3];
   // Stage 1: cofactors.
   cof_type  cof1_ff [3][3];
   elem_type col0_2_ff [3];
   // Stage 2: determinant partial products.
   logic signed [COF_W:0]   lo_ff [3];
   logic signed [COF_W-1:0] hi_ff [3];
   cof_type                 cof2_ff [3][3];
   // Stage 3: full determinant terms.
   logic signed [PROD_W-1:0] term_ff [3];
   cof_type                  cof3_ff [3][3];
   // Stage 4: determinant.
   logic signed [DET_W-1:0] det_ff;
   cof_type                 cof4_ff [3][3];

   // Divider stages; index 0 is the magnitude and threshold stage.
   logic [REM_W-1:0]  rem_ff  [DIV_STEPS+1][9];
   logic [QUO_W-1:0]  quo_ff  [DIV_STEPS+1][9];
   logic              ovf_ff  [DIV_STEPS+1][9];
   logic              neg_ff  [DIV_STEPS+1][9];
   logic [DMAG_W-1:0] dmag_ff [DIV_STEPS+1];
   logic              sing_ff [DIV_STEPS+1];

   // Output register.
   elem_type inv_ff [9];
   logic     sing_out_ff;
   logic     ovf_out_ff;

   // Magnitude stage combinational values.
   logic              det_neg;
   logic [DET_W-1:0]  det_abs;
   logic [REM_W-1:0]  rem0_in  [9];
   logic              ovf0_in  [9];
   logic              neg0_in  [9];
   logic              sing0_in;
   cof_type           cof_flat [9];
   logic [COF_W-1:0]  cmag     [9];

   // Output stage combinational values.
   elem_type inv_in [9];
   logic     ovf_any_in;

   // ------------------------------------------------------------------
   // Configuration port. Bit 3 of the address selects the register.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_reg_type'(csr_paddr[3]) == REG_DET_THRESHOLD)) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   always_comb begin
      if (csr_reg_type'(csr_paddr[3]) == REG_DET_THRESHOLD) begin
         csr_prdata = {{(CSR_DW-THR_W){1'b0}}, thr_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its beat moves on.
   // ------------------------------------------------------------------
   always_comb begin
      ld[NSTG-1] = !v_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   assign req_ready = ld[0];
   assign rsp_valid = v_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: the 18 element products. Cofactor (r, c) uses columns
   // (r+1) and (r+2) and rows (c+1) and (c+2), all mod 3.
   // ------------------------------------------------------------------
   always_comb begin
      m_in[0][0] = req_in_r0c0;
      m_in[0][1] = req_in_r0c1;
      m_in[0][2] = req_in_r0c2;
      m_in[1][0] = req_in_r1c0;
      m_in[1][1] = req_in_r1c1;
      m_in[1][2] = req_in_r1c2;
      m_in[2][0] = req_in_r2c0;
      m_in[2][1] = req_in_r2c1;
      m_in[2][2] = req_in_r2c2;
   end

   for (genvar r = 0; r < 3; r++) begin : g_cof_r
      for (genvar c = 0; c < 3; c++) begin : g_cof_c
         localparam int CA = (r + 1) % 3;
         localparam int CB = (r + 2) % 3;
         localparam int R1 = (c + 1) % 3;
         localparam int R2 = (c + 2) % 3;
         always_ff @(posedge clock) begin
            if (ld[0]) begin
               pa_ff[r][c] <= m_in[R1][CA] * m_in[R2][CB];
               pb_ff[r][c] <= m_in[R2][CA] * m_in[R1][CB];
            end
            if (ld[1]) begin
               cof1_ff[r][c] <= pa_ff[r][c] - pb_ff[r][c];
            end
            if (ld[2]) begin
               cof2_ff[r][c] <= cof1_ff[r][c];
            end
            if (ld[3]) begin
               cof3_ff[r][c] <= cof2_ff[r][c];
            end
            if (ld[4]) begin
               cof4_ff[r][c] <= cof3_ff[r][c];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stages 1 to 4: determinant = row 0 of the cofactors dotted with
   // column 0. Each 64x32 product is split at bit 32 into two multipliers.
   // ------------------------------------------------------------------
   for (genvar t = 0; t < 3; t++) begin : g_det
      always_ff @(posedge clock) begin
         if (ld[0]) begin
            col0_1_ff[t] <= m_in[t][0];
         end
         if (ld[1]) begin
            col0_2_ff[t] <= col0_1_ff[t];
         end
         if (ld[2]) begin
            lo_ff[t] <= $signed({1'b0, cof1_ff[0][t][31:0]}) * col0_2_ff[t];
            hi_ff[t] <= $signed(cof1_ff[0][t][COF_W-1:32]) * col0_2_ff[t];
         end
         if (ld[3]) begin
            term_ff[t] <= $signed({hi_ff[t], 32'b0}) +
                          $signed({{(PROD_W-COF_W-1){lo_ff[t][COF_W]}}, lo_ff[t]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         det_ff <= DET_W'(term_ff[0]) + DET_W'(term_ff[1]) + DET_W'(term_ff[2]);
      end
   end

   // ------------------------------------------------------------------
   // Magnitude stage: |det|, threshold compare, cofactor magnitudes and
   // signs, and the early overflow test (quotient at or above 2^33).
   // ------------------------------------------------------------------
   always_comb begin
      det_neg  = det_ff[DET_W-1];
      det_abs  = det_neg ? DET_W'(-det_ff) : det_ff;
      sing0_in = (det_abs[DET_W-1:THR_W] == '0) && (det_abs[THR_W-1:0] <= thr_ff);
      for (int e = 0; e < 9; e++) begin
         cof_flat[e] = cof4_ff[e / 3][e % 3];
         cmag[e]     = cof_flat[e][COF_W-1] ? COF_W'(-cof_flat[e]) : cof_flat[e];
         rem0_in[e]  = {cmag[e], 32'b0};
         neg0_in[e]  = cof_flat[e][COF_W-1] != det_neg;
         ovf0_in[e]  = {{(DMAG_W-COF_W+1){1'b0}}, cmag[e][COF_W-1:1]} >=
                       det_abs[DMAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_DIV0]) begin
         dmag_ff[0] <= det_abs[DMAG_W-1:0];
         sing_ff[0] <= sing0_in;
         for (int e = 0; e < 9; e++) begin
            rem_ff[0][e] <= rem0_in[e];
            quo_ff[0][e] <= '0;
            ovf_ff[0][e] <= ovf0_in[e];
            neg_ff[0][e] <= neg0_in[e];
         end
      end
   end

   // ------------------------------------------------------------------
   // Restoring divider: step j decides quotient bit DIV_STEPS-j.
   // ------------------------------------------------------------------
   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      localparam int BIT = DIV_STEPS - j;
      localparam int CW  = REM_W + QUO_W;
      logic [CW-1:0]    dsh;
      logic [CW-1:0]    rwide [9];
      logic             ge    [9];
      logic [REM_W-1:0] rem_in [9];
      logic [QUO_W-1:0] quo_in [9];

      always_comb begin
         dsh = {{(CW-DMAG_W){1'b0}}, dmag_ff[j-1]} << BIT;
         for (int e = 0; e < 9; e++) begin
            rwide[e]  = {{(CW-REM_W){1'b0}}, rem_ff[j-1][e]};
            ge[e]     = rwide[e] >= dsh;
            rem_in[e] = ge[e] ? REM_W'(rwide[e] - dsh) : rem_ff[j-1][e];
            quo_in[e] = quo_ff[j-1][e];
            quo_in[e][BIT] = ge[e];
         end
      end

      always_ff @(posedge clock) begin
         if (ld[STG_DIV0+j]) begin
            dmag_ff[j] <= dmag_ff[j-1];
            sing_ff[j] <= sing_ff[j-1];
            for (int e = 0; e < 9; e++) begin
               rem_ff[j][e] <= rem_in[e];
               quo_ff[j][e] <= quo_in[e];
               ovf_ff[j][e] <= ovf_ff[j-1][e];
               neg_ff[j][e] <= neg_ff[j-1][e];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: saturate to Q16.16, apply the sign, or force zeros
   // for a singular matrix.
   // ------------------------------------------------------------------
   always_comb begin
      logic [QUO_W-1:0]  limit;
      logic              sat;
      logic [ELEM_W-1:0] mag;
      ovf_any_in = 1'b0;
      for (int e = 0; e < 9; e++) begin
         limit = neg_ff[DIV_STEPS][e] ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
         sat   = ovf_ff[DIV_STEPS][e] || (quo_ff[DIV_STEPS][e] > limit);
         mag   = sat ? limit[ELEM_W-1:0] : quo_ff[DIV_STEPS][e][ELEM_W-1:0];
         if (sing_ff[DIV_STEPS]) begin
            inv_in[e] = '0;
         end else begin
            inv_in[e]  = neg_ff[DIV_STEPS][e] ? elem_type'(-mag) : elem_type'(mag);
            ovf_any_in = ovf_any_in || sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[NSTG-1]) begin
         inv_ff      <= inv_in;
         sing_out_ff <= sing_ff[DIV_STEPS];
         ovf_out_ff  <= ovf_any_in;
      end
   end

   assign rsp_inv_r0c0 = inv_ff[0];
   assign rsp_inv_r0c1 = inv_ff[1];
   assign rsp_inv_r0c2 = inv_ff[2];
   assign rsp_inv_r1c0 = inv_ff[3];
   assign rsp_inv_r1c1 = inv_ff[4];
   assign rsp_inv_r1c2 = inv_ff[5];
   assign rsp_inv_r2c0 = inv_ff[6];
   assign rsp_inv_r2c1 = inv_ff[7];
   assign rsp_inv_r2c2 = inv_ff[8];
   assign rsp_singular = sing_out_ff;
   assign rsp_overflow = ovf_out_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_sing_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_overflow)
      else $error("singular beat carries overflow");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> (rsp_inv_r0c0 == '0) && (rsp_inv_r1c1 == '0) &&
                                    (rsp_inv_r2c2 == '0) && (rsp_inv_r0c2 == '0))
      else $error("singular beat carries nonzero elements");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("accepted request beat did not enter the pipeline");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && (v_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
